### hw/rtl/dps_pkg.sv
package dps_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int LCG_ROUNDS  = 10;
   localparam int CELLS       = MAX_WIDTH * MAX_HEIGHT;
   localparam int CELL_AW     = $clog2(CELLS);
   localparam int ROUND_W     = 4;
   localparam int SEED_W      = 17;
   localparam int COORD_W     = 8;
   localparam int DIM_W       = 9;
   localparam int PROD_W      = SEED_W + DIM_W;

   localparam logic [SEED_W-1:0] LCG_MUL = 17'd75;
   localparam logic [SEED_W:0]   LCG_MOD = 18'd65537;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'd1;

   localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 9'd200;
   localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 9'd200;

   typedef enum logic [1:0] {
      OP_STICK  = 2'd0,
      OP_MOVE   = 2'd1,
      OP_OCCUPY = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_NBR,
      S_DRAIN,
      S_MARK,
      S_LCG,
      S_STEP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [SEED_W-1:0]  a;
      logic [DIM_W-1:0]   b;
      logic [COORD_W-1:0] c;
   } alu_req_type;

   typedef struct packed {
      logic               we;
      logic [CELL_AW-1:0] waddr;
      logic               wdata;
      logic [CELL_AW-1:0] raddr;
   } ram_req_type;

   // Neighbour offsets as ten-bit two's complement values; the centre is skipped.
   function automatic logic [9:0] nbr_dx(input logic [2:0] k);
      logic [9:0] d;
      unique case (k)
         3'd0, 3'd1, 3'd2: d = 10'h3FF;
         3'd3, 3'd4:       d = 10'h000;
         default:          d = 10'h001;
      endcase
      return d;
   endfunction

   function automatic logic [9:0] nbr_dy(input logic [2:0] k);
      logic [9:0] d;
      unique case (k)
         3'd0, 3'd3, 3'd5: d = 10'h3FF;
         3'd1, 3'd6:       d = 10'h000;
         default:          d = 10'h001;
      endcase
      return d;
   endfunction

endpackage

### hw/rtl/dps_ram.sv
module dps_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dps_alu.sv
module dps_alu (
   input  dps_pkg::alu_req_type          alu_req,
   output logic [dps_pkg::CELL_AW-1:0]   prod_lo,
   output logic [dps_pkg::SEED_W-1:0]    mod_out
);

   logic [dps_pkg::PROD_W-1:0] prod;
   logic [9:0]                 prod_hi;
   logic [dps_pkg::SEED_W:0]   diff;
   logic [dps_pkg::SEED_W:0]   diff_fix;

   // One multiply-add serves both the cell index (row * width + column) and
   // a generator round. Since 2^16 is -1 modulo 65537, the product reduces
   // as low half minus high half, with one correction when that goes negative.
   always_comb begin
      prod     = dps_pkg::PROD_W'(alu_req.a) * dps_pkg::PROD_W'(alu_req.b)
                 + dps_pkg::PROD_W'(alu_req.c);
      prod_hi  = prod[dps_pkg::PROD_W-1:16];
      diff     = {2'b00, prod[15:0]} - {8'd0, prod_hi};
      diff_fix = diff + dps_pkg::LCG_MOD;
      prod_lo  = prod[dps_pkg::CELL_AW-1:0];
      mod_out  = diff[dps_pkg::SEED_W] ? diff_fix[dps_pkg::SEED_W-1:0]
                                       : diff[dps_pkg::SEED_W-1:0];
   end

endmodule

### hw/rtl/dps_ctrl.sv
module dps_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [dps_pkg::COORD_W-1:0]   req_pos_x,
   input  logic [dps_pkg::COORD_W-1:0]   req_pos_y,
   input  logic [dps_pkg::SEED_W-1:0]    req_walk_seed,
   input  logic [dps_pkg::DIM_W-1:0]     grid_w,
   input  logic [dps_pkg::DIM_W-1:0]     grid_h,
   input  logic [dps_pkg::CELL_AW-1:0]   alu_prod,
   input  logic [dps_pkg::SEED_W-1:0]    alu_mod,
   input  logic                          ram_rd_data,
   output dps_pkg::alu_req_type          alu_req,
   output dps_pkg::ram_req_type          ram_req,
   output logic                          rsp_valid,
   output logic                          rsp_stuck,
   output logic [dps_pkg::COORD_W-1:0]   rsp_new_x,
   output logic [dps_pkg::COORD_W-1:0]   rsp_new_y,
   output logic [dps_pkg::SEED_W-1:0]    rsp_new_seed
);

   localparam logic [dps_pkg::CELL_AW-1:0] CLR_LAST = dps_pkg::CELL_AW'(dps_pkg::CELLS - 1);
   localparam logic [dps_pkg::ROUND_W-1:0] ROUND_LAST =
      dps_pkg::ROUND_W'(dps_pkg::LCG_ROUNDS - 1);

   dps_pkg::state_type state_ff, state_in;

   logic [dps_pkg::CELL_AW-1:0] clr_ff, clr_in;
   logic [2:0]                  nb_ff, nb_in;
   logic [dps_pkg::ROUND_W-1:0] round_ff, round_in;
   logic                        pend_ff, pend_in;
   logic                        hit_ff, hit_in;
   logic                        stuck_ff, stuck_in;
   logic [dps_pkg::COORD_W-1:0] x_ff, x_in;
   logic [dps_pkg::COORD_W-1:0] y_ff, y_in;
   logic [dps_pkg::SEED_W-1:0]  seed_ff, seed_in;

   logic [dps_pkg::COORD_W-1:0] w_m1, h_m1, x_sat, y_sat;
   logic [9:0]                  nx, ny;
   logic                        nbr_valid;
   logic                        accept;
   logic [dps_pkg::COORD_W:0]   x_inc, y_inc;

   always_comb begin
      w_m1      = dps_pkg::COORD_W'(grid_w - 9'd1);
      h_m1      = dps_pkg::COORD_W'(grid_h - 9'd1);
      x_sat     = (req_pos_x > w_m1) ? w_m1 : req_pos_x;
      y_sat     = (req_pos_y > h_m1) ? h_m1 : req_pos_y;
      // A column or row of minus one wraps to a large value and fails the bound.
      nx        = {2'b00, x_ff} + dps_pkg::nbr_dx(nb_ff);
      ny        = {2'b00, y_ff} + dps_pkg::nbr_dy(nb_ff);
      nbr_valid = (nx < {1'b0, grid_w}) && (ny < {1'b0, grid_h});
      accept    = start && (state_ff == dps_pkg::S_IDLE);
      hit_in    = hit_ff | (pend_ff & ram_rd_data);
      x_inc     = {1'b0, x_ff} + 9'd1;
      y_inc     = {1'b0, y_ff} + 9'd1;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dps_pkg::S_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = dps_pkg::S_IDLE;
            end
         end
         dps_pkg::S_IDLE: begin
            if (start) begin
               unique case (dps_pkg::op_type'(req_op))
                  dps_pkg::OP_STICK:  state_in = dps_pkg::S_NBR;
                  dps_pkg::OP_MOVE:   state_in = dps_pkg::S_LCG;
                  dps_pkg::OP_OCCUPY: state_in = dps_pkg::S_MARK;
                  dps_pkg::OP_NONE:   state_in = dps_pkg::S_RESP;
               endcase
            end
         end
         dps_pkg::S_NBR: begin
            if (nb_ff == 3'd7) begin
               state_in = dps_pkg::S_DRAIN;
            end
         end
         dps_pkg::S_DRAIN: state_in = hit_in ? dps_pkg::S_MARK : dps_pkg::S_RESP;
         dps_pkg::S_MARK:  state_in = dps_pkg::S_RESP;
         dps_pkg::S_LCG: begin
            if (round_ff == ROUND_LAST) begin
               state_in = dps_pkg::S_STEP;
            end
         end
         dps_pkg::S_STEP:  state_in = dps_pkg::S_RESP;
         dps_pkg::S_RESP:  state_in = dps_pkg::S_IDLE;
         default:          state_in = dps_pkg::S_CLEAR;
      endcase
   end

   // Outputs and shared-unit operand selection.
   always_comb begin
      busy          = (state_ff != dps_pkg::S_IDLE);
      rsp_valid     = (state_ff == dps_pkg::S_RESP);
      alu_req.a     = dps_pkg::SEED_W'(y_ff);
      alu_req.b     = grid_w;
      alu_req.c     = x_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = alu_prod;
      ram_req.wdata = 1'b1;
      ram_req.raddr = alu_prod;
      unique case (state_ff)
         dps_pkg::S_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = clr_ff;
            ram_req.wdata = 1'b0;
         end
         dps_pkg::S_NBR: begin
            alu_req.a = dps_pkg::SEED_W'(ny[dps_pkg::COORD_W-1:0]);
            alu_req.c = nx[dps_pkg::COORD_W-1:0];
         end
         dps_pkg::S_MARK: begin
            ram_req.we = 1'b1;
         end
         dps_pkg::S_LCG: begin
            alu_req.a = seed_ff;
            alu_req.b = dps_pkg::DIM_W'(dps_pkg::LCG_MUL);
            alu_req.c = '0;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_in   = clr_ff;
      nb_in    = nb_ff;
      round_in = round_ff;
      pend_in  = (state_ff == dps_pkg::S_NBR) && nbr_valid;
      stuck_in = stuck_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      seed_in  = seed_ff;
      unique case (state_ff)
         dps_pkg::S_CLEAR: clr_in = clr_ff + 1'b1;
         dps_pkg::S_NBR:   nb_in = nb_ff + 3'd1;
         dps_pkg::S_MARK:  stuck_in = 1'b1;
         dps_pkg::S_LCG: begin
            seed_in  = alu_mod;
            round_in = round_ff + 1'b1;
         end
         dps_pkg::S_STEP: begin
            unique case (seed_ff[1:0])
               2'd0: x_in = (x_inc >= grid_w) ? '0 : x_inc[dps_pkg::COORD_W-1:0];
               2'd1: x_in = (x_ff == '0) ? w_m1 : x_ff - 8'd1;
               2'd2: y_in = (y_inc >= grid_h) ? '0 : y_inc[dps_pkg::COORD_W-1:0];
               2'd3: y_in = (y_ff == '0) ? h_m1 : y_ff - 8'd1;
            endcase
         end
         default: begin
         end
      endcase
      if (accept) begin
         nb_in    = '0;
         round_in = '0;
         stuck_in = (dps_pkg::op_type'(req_op) == dps_pkg::OP_OCCUPY);
         x_in     = x_sat;
         y_in     = y_sat;
         seed_in  = req_walk_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dps_pkg::S_CLEAR;
         clr_ff   <= '0;
         nb_ff    <= '0;
         round_ff <= '0;
         pend_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         nb_ff    <= nb_in;
         round_ff <= round_in;
         pend_ff  <= pend_in;
         hit_ff   <= accept ? 1'b0 : hit_in;
      end
      stuck_ff <= stuck_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      seed_ff  <= seed_in;
   end

   assign rsp_stuck    = stuck_ff;
   assign rsp_new_x    = x_ff;
   assign rsp_new_y    = y_ff;
   assign rsp_new_seed = seed_ff;

endmodule

### hw/rtl/dla_particle_step_engine.sv
// Particle step engine for diffusion-limited aggregation on a grid of up to
// 256 by 256 cells, holding the occupancy bitmap in a one-bit memory.
// Commands: raise start with req_op, req_pos_x, req_pos_y and req_walk_seed;
// the transfer happens at a rising edge with start high and busy low. Busy
// stays high until the result has been shown. Exactly one result follows each
// command, on the rsp_ ports for a single cycle marked by rsp_valid; the
// receiver cannot hold it off and must take it in that cycle.
// Before rsp_valid, a stick check makes eight neighbour reads on the single
// memory read port, a drain step and, if the cell gets marked, one write; a
// move runs ten generator rounds through the shared multiply-reduce unit and
// one step; occupy makes one write; op code 3 answers in the cycle after the
// transfer. A new command may follow in the cycle after rsp_valid. After
// reset the bitmap is cleared one cell a cycle while busy stays high. The
// user must write grid size registers through csr_we, csr_index and csr_wdata
// only while the block is idle (not enforced); they reset to 200 by 200.
module dla_particle_step_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_op,
   input  logic [7:0]                      req_pos_x,
   input  logic [7:0]                      req_pos_y,
   input  logic [16:0]                     req_walk_seed,
   output logic                            rsp_valid,
   output logic                            rsp_stuck,
   output logic [7:0]                      rsp_new_x,
   output logic [7:0]                      rsp_new_y,
   output logic [16:0]                     rsp_new_seed,
   input  logic                            csr_we,
   input  logic [dps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dps_pkg::DIM_W-1:0]       csr_wdata
);

   logic [dps_pkg::DIM_W-1:0] grid_width_ff, grid_width_in;
   logic [dps_pkg::DIM_W-1:0] grid_height_ff, grid_height_in;
   logic [dps_pkg::DIM_W-1:0] grid_w, grid_h;

   dps_pkg::alu_req_type        alu_req;
   dps_pkg::ram_req_type        ram_req;
   logic [dps_pkg::CELL_AW-1:0] alu_prod;
   logic [dps_pkg::SEED_W-1:0]  alu_mod;
   logic                        ram_rd_data;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_we && (csr_index == dps_pkg::CSR_GRID_WIDTH)) begin
         grid_width_in = csr_wdata;
      end
      if (csr_we && (csr_index == dps_pkg::CSR_GRID_HEIGHT)) begin
         grid_height_in = csr_wdata;
      end
      // A size of zero acts as one, anything above the maximum as the maximum.
      priority if (grid_width_ff == '0) begin
         grid_w = 9'd1;
      end else if (grid_width_ff > dps_pkg::DIM_W'(dps_pkg::MAX_WIDTH)) begin
         grid_w = dps_pkg::DIM_W'(dps_pkg::MAX_WIDTH);
      end else begin
         grid_w = grid_width_ff;
      end
      priority if (grid_height_ff == '0) begin
         grid_h = 9'd1;
      end else if (grid_height_ff > dps_pkg::DIM_W'(dps_pkg::MAX_HEIGHT)) begin
         grid_h = dps_pkg::DIM_W'(dps_pkg::MAX_HEIGHT);
      end else begin
         grid_h = grid_height_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= dps_pkg::GRID_WIDTH_RST;
         grid_height_ff <= dps_pkg::GRID_HEIGHT_RST;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   dps_alu u_alu (
      .alu_req (alu_req),
      .prod_lo (alu_prod),
      .mod_out (alu_mod)
   );

   dps_ram #(
      .WIDTH (1),
      .DEPTH (dps_pkg::CELLS)
   ) u_occupancy (
      .clock   (clock),
      .wr_en   (ram_req.we),
      .wr_addr (ram_req.waddr),
      .wr_data (ram_req.wdata),
      .rd_addr (ram_req.raddr),
      .rd_data (ram_rd_data)
   );

   dps_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_walk_seed (req_walk_seed),
      .grid_w        (grid_w),
      .grid_h        (grid_h),
      .alu_prod      (alu_prod),
      .alu_mod       (alu_mod),
      .ram_rd_data   (ram_rd_data),
      .alu_req       (alu_req),
      .ram_req       (ram_req),
      .rsp_valid     (rsp_valid),
      .rsp_stuck     (rsp_stuck),
      .rsp_new_x     (rsp_new_x),
      .rsp_new_y     (rsp_new_y),
      .rsp_new_seed  (rsp_new_seed)
   );

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command transfer did not make the block busy");

   a_write_busy : assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> busy)
      else $error("bitmap written while idle");

   // The unused op code answers in the cycle straight after its transfer.
   a_rsp_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy && ($past(busy) || $past(start)))
      else $error("result shown without a command in progress");

endmodule
